// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/htb_pkg.sv -----
// shared types and constants for the huffman tree builder
// no dependencies
package htb_pkg;
  localparam int Symbols   = 16;
  localparam int NodeCount = 31;
  localparam int IdxW      = 5;
  localparam int FreqW     = 12;
  localparam int SymFreqW  = 8;
  localparam int LoadW     = 4;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [FreqW-1:0] freq_t;

  typedef struct packed {
    idx_t  node_index;
    idx_t  left_child;
    idx_t  right_child;
    idx_t  parent_index;
    freq_t node_freq;
    logic  last_node;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // write leaf frequency at load count
    logic clr;       // clear node slot scan_idx
    logic scan_rst;  // start a new search
    logic scan;      // evaluate node scan_idx
    logic skip_a;    // second search: skip first pick
    logic take_a;    // latch first pick
    logic merge;     // write inner node new_idx
    logic rd;        // read node scan_idx for emission
    idx_t scan_idx;
    idx_t new_idx;
  } cmd_t;

  typedef struct packed {
    logic found;
  } status_t;
endpackage

// ----- hdl/htb_if.sv -----
// valid/ready channel interfaces for the huffman tree builder
// depends on htb_pkg
interface htb_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [htb_pkg::SymFreqW-1:0] symbol_freq;
  modport source (output valid, output symbol_freq, input ready);
  modport sink (input valid, input symbol_freq, output ready);
endinterface

interface htb_out_if (input logic clk);
  logic valid;
  logic ready;
  htb_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/htb_ctrl.sv -----
// sequencer for load, build and emit phases
// depends on htb_pkg
module htb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_slot_free,
  output logic              res_valid,
  output htb_pkg::cmd_t     cmd,
  input  htb_pkg::status_t  sts
);
  typedef enum logic [2:0] {
    S_LOAD, S_CLR, S_SCAN_A, S_SCAN_B, S_JOIN, S_EMIT
  } state_t;

  state_t state_r;
  logic [htb_pkg::LoadW-1:0] load_cnt_r;
  htb_pkg::idx_t scan_r, new_r;
  logic rd_pend_r;

  localparam htb_pkg::idx_t LastNode = htb_pkg::idx_t'(htb_pkg::NodeCount - 1);
  localparam htb_pkg::idx_t FirstInner = htb_pkg::idx_t'(htb_pkg::Symbols);
  localparam logic [htb_pkg::LoadW-1:0] LastLoad =
    htb_pkg::LoadW'(htb_pkg::Symbols - 1);

  logic acc, emit_go;
  // no new symbol while a node beat is still on its way out
  assign in_ready = (state_r == S_LOAD) && out_slot_free && !rd_pend_r && !res_valid;
  assign acc = in_valid && in_ready;
  // one read in flight at a time; issue when the whole output path is empty
  assign emit_go = (state_r == S_EMIT) && !rd_pend_r && !res_valid && out_slot_free;

  always_comb begin
    cmd = '0;
    cmd.scan_idx = scan_r;
    cmd.new_idx  = new_r;
    cmd.load     = acc;
    cmd.clr      = (state_r == S_CLR);
    cmd.scan     = (state_r == S_SCAN_A) || (state_r == S_SCAN_B);
    cmd.skip_a   = (state_r == S_SCAN_B);
    cmd.scan_rst = (state_r == S_JOIN) || (state_r == S_CLR && scan_r == LastNode)
                   || (state_r == S_SCAN_A && scan_r + 1'b1 == new_r);
    cmd.take_a   = (state_r == S_SCAN_A) && (scan_r + 1'b1 == new_r);
    cmd.merge    = (state_r == S_JOIN);
    cmd.rd       = emit_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      scan_r     <= '0;
      new_r      <= '0;
      rd_pend_r  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= rd_pend_r;
      rd_pend_r <= emit_go;
      unique case (state_r)
        S_LOAD: begin
          if (acc) begin
            if (load_cnt_r == LastLoad) begin
              load_cnt_r <= '0;
              scan_r     <= '0;
              state_r    <= S_CLR;
            end else begin
              load_cnt_r <= load_cnt_r + 1'b1;
            end
          end
        end
        S_CLR: begin
          if (scan_r == LastNode) begin
            scan_r  <= '0;
            new_r   <= FirstInner;
            state_r <= S_SCAN_A;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_SCAN_A: begin
          if (scan_r + 1'b1 == new_r) begin
            scan_r  <= '0;
            state_r <= S_SCAN_B;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_SCAN_B: begin
          if (scan_r + 1'b1 == new_r) state_r <= S_JOIN;
          else scan_r <= scan_r + 1'b1;
        end
        S_JOIN: begin
          scan_r <= '0;
          if (!sts.found || new_r == LastNode) begin
            state_r <= S_EMIT;
          end else begin
            new_r   <= new_r + 1'b1;
            state_r <= S_SCAN_A;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (scan_r == LastNode) begin
              scan_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              scan_r <= scan_r + 1'b1;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ----- hdl/htb_dp.sv -----
// node stores, minimum search and sum for the huffman tree builder
// depends on htb_pkg
module htb_dp (
  input  logic                          clk,
  input  logic [htb_pkg::SymFreqW-1:0]  symbol_freq,
  input  logic [htb_pkg::LoadW-1:0]     load_idx,
  input  htb_pkg::cmd_t                 cmd,
  output htb_pkg::status_t              sts,
  output htb_pkg::result_t              rd_data
);
  localparam int N = htb_pkg::NodeCount;
  htb_pkg::freq_t freq_r   [N];
  htb_pkg::idx_t  par_r    [N];
  htb_pkg::idx_t  left_r   [N];
  htb_pkg::idx_t  right_r  [N];
  logic           found_r, found_b_r;
  htb_pkg::idx_t  best_r, a_r;
  htb_pkg::freq_t best_f_r, a_f_r;

  htb_pkg::freq_t f_cur;
  logic           cand;
  logic           better;
  assign f_cur = freq_r[cmd.scan_idx];
  assign cand  = (par_r[cmd.scan_idx] == '0) && !(cmd.skip_a && cmd.scan_idx == a_r);
  assign better = cand && (!found_r || f_cur < best_f_r);
  // a pair exists only when both searches found a node
  assign sts.found = found_b_r && found_r;

  always_ff @(posedge clk) begin
    if (cmd.load) freq_r[{1'b0, load_idx}] <= htb_pkg::FreqW'(symbol_freq);
    if (cmd.clr) begin
      par_r[cmd.scan_idx]   <= '0;
      left_r[cmd.scan_idx]  <= '0;
      right_r[cmd.scan_idx] <= '0;
      if (cmd.scan_idx >= htb_pkg::idx_t'(htb_pkg::Symbols)) freq_r[cmd.scan_idx] <= '0;
    end
    if (cmd.scan && better) begin
      best_r   <= cmd.scan_idx;
      best_f_r <= f_cur;
    end
    if (cmd.scan_rst) found_r <= 1'b0;
    else if (cmd.scan && better) found_r <= 1'b1;
    if (cmd.take_a) begin
      if (better) begin
        a_r   <= cmd.scan_idx;
        a_f_r <= f_cur;
        found_b_r <= 1'b1;
      end else begin
        a_r   <= best_r;
        a_f_r <= best_f_r;
        found_b_r <= found_r;
      end
    end
    if (cmd.merge) begin
      // found_b_r holds first-search success; found_r the second
      if (found_b_r && found_r) begin
        left_r[cmd.new_idx]  <= a_r;
        right_r[cmd.new_idx] <= best_r;
        freq_r[cmd.new_idx]  <= htb_pkg::FreqW'(a_f_r + best_f_r);
        par_r[a_r]           <= cmd.new_idx;
        par_r[best_r]        <= cmd.new_idx;
      end else begin
        found_b_r <= 1'b0;
      end
    end
    if (cmd.rd) begin
      rd_data.node_index   <= cmd.scan_idx;
      rd_data.left_child   <= left_r[cmd.scan_idx];
      rd_data.right_child  <= right_r[cmd.scan_idx];
      rd_data.parent_index <= par_r[cmd.scan_idx];
      rd_data.node_freq    <= freq_r[cmd.scan_idx];
      rd_data.last_node    <= (cmd.scan_idx == htb_pkg::idx_t'(htb_pkg::NodeCount - 1));
    end
  end
endmodule

// ----- hdl/huffman_tree_builder.sv -----
// huffman tree builder: load 16 symbol frequencies, build a tree, emit 31 nodes
// top level; depends on htb_pkg, htb_if, htb_ctrl, htb_dp
// One 8-bit frequency is taken per input beat, one beat per cycle while loading
// and the output register is empty. The beat carrying the last symbol starts a
// build: a clearing sweep over all 31 nodes, then for each of the 15 inner nodes
// two linear minimum searches over the nodes created so far (one node per cycle)
// and one join step. The block then emits all 31 nodes in index order, one read
// at a time, the next read issued only once the output register has emptied,
// with last_node on node 30, and takes the next symbol once the final node has
// left the output register. Ties in a search go to the lowest index; zero-frequency
// leaves take part. A missing pair ends the build early and the remaining nodes
// read as zero.
module huffman_tree_builder (
  input logic clk,
  input logic rst_n,
  htb_in_if.sink    in_ch,
  htb_out_if.source out_ch
);
  htb_pkg::cmd_t    cmd;
  htb_pkg::status_t sts;
  htb_pkg::result_t rd_data;
  logic res_valid;
  logic out_valid_r;
  htb_pkg::result_t out_data_r;
  logic [htb_pkg::LoadW-1:0] load_idx_r;

  // output register; the controller only reads when it is empty
  logic slot_free;
  assign slot_free = !out_valid_r;

  htb_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_slot_free(slot_free),
    .res_valid, .cmd, .sts
  );

  // mirror of the load counter for the leaf write address
  always_ff @(posedge clk) begin
    if (!rst_n) load_idx_r <= '0;
    else if (cmd.load) load_idx_r <= load_idx_r + 1'b1;
  end

  htb_dp u_dp (
    .clk, .symbol_freq(in_ch.symbol_freq), .load_idx(load_idx_r),
    .cmd, .sts, .rd_data
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data_r <= rd_data;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
endmodule

// ----- hdl/htb_checker.sv -----
// port-level checker for huffman_tree_builder, bound to the top level
// depends on assert_macros.svh, htb_pkg
`include "assert_macros.svh"
module htb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input htb_pkg::result_t out_data
);
  `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `ASSERT_IMPLY(a_last_idx, clk, rst_n, out_valid && out_data.last_node,
                out_data.node_index == htb_pkg::idx_t'(htb_pkg::NodeCount - 1))
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPLY(a_leaf_kids, clk, rst_n,
                out_valid && out_data.node_index < htb_pkg::idx_t'(htb_pkg::Symbols),
                out_data.left_child == '0 && out_data.right_child == '0)
endmodule

bind huffman_tree_builder htb_checker u_htb_checker (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
